FILE: src/alir_pkg.sv
// Shared types and constants of the array list insert/remove core.
package alir_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KIND_W       = 3;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 6;
    localparam int STAT_W       = 3;
    localparam int CNT_OUT_W    = 7;

    // Command codes; codes above K_READ are ignored
    typedef enum logic [KIND_W-1:0] {
        K_INSERT     = 3'd0,
        K_REMOVE_AT  = 3'd1,
        K_REMOVE_ONE = 3'd2,
        K_REMOVE_ALL = 3'd3,
        K_READ       = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RANGE     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Decoder verdict on one command
    typedef struct packed {
        logic    run;
        t_status status;
    } t_plan;

endpackage

FILE: src/alir_cmd_if.sv
// Command channel: valid/ready handshake with kind, value and position.
interface alir_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [alir_pkg::KIND_W-1:0]           kind;
    logic signed [alir_pkg::VAL_W-1:0]     value;
    logic [alir_pkg::POS_W-1:0]            position;

    modport source (output valid, kind, value, position, input ready);
    modport sink   (input valid, kind, value, position, output ready);
endinterface

FILE: src/alir_rsp_if.sv
// Response channel: valid/ready handshake with status, length, count and data.
interface alir_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [alir_pkg::STAT_W-1:0]           status;
    logic [alir_pkg::CNT_OUT_W-1:0]        length_after;
    logic [alir_pkg::CNT_OUT_W-1:0]        removed_count;
    logic signed [alir_pkg::VAL_W-1:0]     read_data;

    modport source (output valid, status, length_after, removed_count, read_data,
                    input ready);
    modport sink   (input valid, status, length_after, removed_count, read_data,
                    output ready);
endinterface

FILE: src/alir_decode.sv
// Command check: status for rejected commands, scan start and read count.
module alir_decode #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic [alir_pkg::KIND_W-1:0]        i_kind,
    input  logic [alir_pkg::POS_W-1:0]         i_position,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_len,
    output alir_pkg::t_plan                    o_plan,
    output logic [$clog2(CAPACITY)-1:0]        o_start,
    output logic [$clog2(CAPACITY+1)-1:0]      o_cnt
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > alir_pkg::POS_W) ? LEN_W : alir_pkg::POS_W;

    logic [CW-1:0] pos_c;
    logic [CW-1:0] len_c;
    logic          full;

    assign pos_c = CW'(i_position);
    assign len_c = CW'(i_len);
    assign full  = (i_len == LEN_W'(CAPACITY));

    // Validate the command and set up the memory scan
    always_comb begin
        o_plan.run    = 1'b0;
        o_plan.status = alir_pkg::ST_OK;
        o_start       = '0;
        o_cnt         = '0;
        unique case (alir_pkg::t_kind'(i_kind))
            alir_pkg::K_INSERT: begin
                if (full) begin
                    o_plan.status = alir_pkg::ST_FULL;
                end else if (pos_c > len_c) begin
                    o_plan.status = alir_pkg::ST_RANGE;
                end else begin
                    // walk down from the last entry to the slot being opened
                    o_plan.run = 1'b1;
                    o_start    = AW'(len_c - CW'(1));
                    o_cnt      = LEN_W'(len_c - pos_c);
                end
            end
            alir_pkg::K_REMOVE_AT: begin
                if (pos_c >= len_c) begin
                    o_plan.status = alir_pkg::ST_RANGE;
                end else begin
                    o_plan.run = 1'b1;
                    o_start    = AW'(pos_c);
                    o_cnt      = LEN_W'(len_c - pos_c);
                end
            end
            alir_pkg::K_REMOVE_ONE, alir_pkg::K_REMOVE_ALL: begin
                if (i_len == '0) begin
                    o_plan.status = alir_pkg::ST_EMPTY;
                end else begin
                    o_plan.run = 1'b1;
                    o_cnt      = i_len;
                end
            end
            alir_pkg::K_READ: begin
                if (pos_c >= len_c) begin
                    o_plan.status = alir_pkg::ST_RANGE;
                end else begin
                    o_plan.run = 1'b1;
                    o_start    = AW'(pos_c);
                    o_cnt      = LEN_W'(1);
                end
            end
            default: begin
                o_plan.run = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/alir_engine.sv
// Entry memory with its read-modify-write sequencer and the response register.
module alir_engine #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  logic [alir_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [alir_pkg::VAL_W-1:0]   i_value,
    input  logic [alir_pkg::POS_W-1:0]          i_position,
    input  alir_pkg::t_plan                     i_plan,
    input  logic [$clog2(CAPACITY)-1:0]         i_start,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_cnt,
    output logic [$clog2(CAPACITY+1)-1:0]       o_len,
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_ready,
    output logic [alir_pkg::STAT_W-1:0]         o_status,
    output logic [alir_pkg::CNT_OUT_W-1:0]      o_length_after,
    output logic [alir_pkg::CNT_OUT_W-1:0]      o_removed_count,
    output logic signed [alir_pkg::VAL_W-1:0]   o_read_data
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Entry store, one write and one registered read per cycle
    logic signed [alir_pkg::VAL_W-1:0] mem [CAPACITY];
    logic signed [alir_pkg::VAL_W-1:0] r_rd_data;

    t_state                            r_state, n_state;
    alir_pkg::t_kind                   r_kind;
    alir_pkg::t_status                 r_status;
    logic signed [alir_pkg::VAL_W-1:0] r_val;
    logic [AW-1:0]                     r_pos;
    logic [AW-1:0]                     r_ptr;
    logic [AW-1:0]                     r_wp;
    logic [LEN_W-1:0]                  r_cnt;
    logic [LEN_W-1:0]                  r_len;
    logic [LEN_W-1:0]                  r_removed;
    logic                              r_found;
    logic                              r_rd_vld;
    logic [AW-1:0]                     r_rd_idx;
    logic signed [alir_pkg::VAL_W-1:0] r_data;

    logic                              accept;
    logic                              rd_en;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [alir_pkg::VAL_W-1:0] wr_data;
    logic                              drop;
    logic                              is_compact;
    logic                              scan_done;
    logic                              out_load;
    alir_pkg::t_status                 fin_status;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign o_len       = r_len;
    assign is_compact  = (r_kind == alir_pkg::K_REMOVE_AT) ||
                         (r_kind == alir_pkg::K_REMOVE_ONE) ||
                         (r_kind == alir_pkg::K_REMOVE_ALL);
    assign rd_en       = (r_state == S_SCAN) && (r_cnt != '0);
    assign scan_done   = (r_state == S_SCAN) && (r_cnt == '0) && !r_rd_vld;
    assign out_load    = (r_state == S_FIN) && (!o_rsp_valid || i_rsp_ready);

    // Decide whether a returning entry leaves the list
    always_comb begin
        drop = 1'b0;
        priority if (r_kind == alir_pkg::K_REMOVE_AT) begin
            drop = (r_rd_idx == r_pos);
        end else if (r_kind == alir_pkg::K_REMOVE_ONE) begin
            drop = (r_rd_data == r_val) && !r_found;
        end else if (r_kind == alir_pkg::K_REMOVE_ALL) begin
            drop = (r_rd_data == r_val);
        end else begin
            drop = 1'b0;
        end
    end

    // Write back: shift up for insert, compact for removals, then place the new word
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_data = r_rd_data;
        if (r_state == S_SCAN) begin
            if (r_rd_vld) begin
                if (r_kind == alir_pkg::K_INSERT) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_rd_idx + AW'(1));
                end else if (is_compact && !drop) begin
                    wr_en   = 1'b1;
                end
            end else if ((r_cnt == '0) && (r_kind == alir_pkg::K_INSERT)) begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    // Sequence: idle, scan the memory, hand the result over
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                n_state = i_plan.run ? S_SCAN : S_FIN;
            end
            S_SCAN: if (scan_done) begin
                n_state = S_FIN;
            end
            S_FIN: if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        fin_status = r_status;
        if ((r_status == alir_pkg::ST_OK) && (r_removed == '0) &&
            ((r_kind == alir_pkg::K_REMOVE_ONE) || (r_kind == alir_pkg::K_REMOVE_ALL))) begin
            fin_status = alir_pkg::ST_NOT_FOUND;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_rd_vld    <= 1'b0;
            o_rsp_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (scan_done) begin
                r_len <= (r_kind == alir_pkg::K_INSERT) ? LEN_W'(r_len + LEN_W'(1))
                                                        : LEN_W'(r_len - r_removed);
            end
            if (out_load) begin
                o_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
        end
    end

    // Command capture, scan pointers and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= alir_pkg::t_kind'(i_kind);
            r_status  <= i_plan.status;
            r_val     <= i_value;
            r_pos     <= AW'(i_position);
            r_ptr     <= i_start;
            r_wp      <= i_start;
            r_cnt     <= i_plan.run ? i_cnt : '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_data    <= '0;
        end else if (r_state == S_SCAN) begin
            if (rd_en) begin
                r_ptr    <= (r_kind == alir_pkg::K_INSERT) ? AW'(r_ptr - AW'(1))
                                                           : AW'(r_ptr + AW'(1));
                r_cnt    <= LEN_W'(r_cnt - LEN_W'(1));
                r_rd_idx <= r_ptr;
            end
            if (r_rd_vld) begin
                if (r_kind == alir_pkg::K_READ) begin
                    r_data <= r_rd_data;
                end else if (is_compact) begin
                    if (drop) begin
                        r_found   <= 1'b1;
                        r_removed <= LEN_W'(r_removed + LEN_W'(1));
                    end else begin
                        r_wp <= AW'(r_wp + AW'(1));
                    end
                end
            end
        end
        if (out_load) begin
            o_status        <= fin_status;
            o_length_after  <= alir_pkg::CNT_OUT_W'(r_len);
            o_removed_count <= alir_pkg::CNT_OUT_W'(r_removed);
            o_read_data     <= r_data;
        end
    end

endmodule

FILE: src/array_list_insert_remove_core.sv
// Top level of the packed list store with insert, remove and read commands.
//
// Usage:
//   i_cmd carries one command per beat (kind, value, position); o_rsp returns
//   exactly one beat per command with status, length after, removed count and
//   read data. Both channels transfer when valid and ready are high together.
//   Entries live in one synchronous memory of CAPACITY words; a command that
//   passes the check is worked as a scan that reads one entry a cycle; inserts
//   and removals write it back shifted, so the memory port pair sets the pace.
// One command is in work at a time; i_cmd.ready is high again the cycle after
// the response is loaded, so a new command is taken while the previous
// response still waits on o_rsp. If the receiver stalls, the finished
// result of the next command holds until the response register frees up.
// Reset (synchronous, active low) empties the list; memory contents are not
// cleared, entries beyond the length are never read.
module array_list_insert_remove_core #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    alir_cmd_if.sink    i_cmd,
    alir_rsp_if.source  o_rsp
);
    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);

    alir_pkg::t_plan    plan;
    logic [AW-1:0]      start;
    logic [LEN_W-1:0]   cnt;
    logic [LEN_W-1:0]   len;

    // Check the incoming command against the current length
    alir_decode #(.CAPACITY(CAPACITY)) u_decode (
        .i_kind     (i_cmd.kind),
        .i_position (i_cmd.position),
        .i_len      (len),
        .o_plan     (plan),
        .o_start    (start),
        .o_cnt      (cnt)
    );

    // Run the memory scan and hold the response
    alir_engine #(.CAPACITY(CAPACITY)) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_cmd.valid),
        .o_cmd_ready     (i_cmd.ready),
        .i_kind          (i_cmd.kind),
        .i_value         (i_cmd.value),
        .i_position      (i_cmd.position),
        .i_plan          (plan),
        .i_start         (start),
        .i_cnt           (cnt),
        .o_len           (len),
        .o_rsp_valid     (o_rsp.valid),
        .i_rsp_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_length_after  (o_rsp.length_after),
        .o_removed_count (o_rsp.removed_count),
        .o_read_data     (o_rsp.read_data)
    );

endmodule

FILE: src/alir_checker.sv
// Port-level checks of the list core and their binding to the top level.
module alir_checker #(
    parameter int CAPACITY = alir_pkg::CAPACITY_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cmd_valid,
    input logic                                i_cmd_ready,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [alir_pkg::STAT_W-1:0]         i_status,
    input logic [alir_pkg::CNT_OUT_W-1:0]      i_length_after,
    input logic [alir_pkg::CNT_OUT_W-1:0]      i_removed_count,
    input logic signed [alir_pkg::VAL_W-1:0]   i_read_data
);

    // A stalled response beat holds its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) &&
        $stable(i_length_after) && $stable(i_removed_count) && $stable(i_read_data))
        else $error("response changed while stalled");

    // Only one command in work: no command beat right after another
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while another is in work");

    // A failed command removes nothing and returns no data
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != alir_pkg::ST_OK) |->
        (i_removed_count == '0) && (i_read_data == '0))
        else $error("failed command reports removals or data");

    // A full report only comes with a full list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == alir_pkg::ST_FULL) |->
        (i_length_after == alir_pkg::CNT_OUT_W'(CAPACITY)))
        else $error("full status with list not at capacity");

endmodule

bind array_list_insert_remove_core alir_checker #(.CAPACITY(CAPACITY)) u_alir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cmd_valid     (i_cmd.valid),
    .i_cmd_ready     (i_cmd.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_length_after  (o_rsp.length_after),
    .i_removed_count (o_rsp.removed_count),
    .i_read_data     (o_rsp.read_data)
);
